// ----- sv/prf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_pkg
// Shared types and constants for the pulse range filter block.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int PRF_TICK_W   = 32;
    localparam int PRF_DIST_W   = 17;
    localparam int PRF_FILT_W   = 25;
    localparam int PRF_THR_W    = 16;
    localparam int PRF_COEF_W   = 16;
    localparam int PRF_PROD_W   = PRF_COEF_W + PRF_DIST_W;
    localparam int PRF_FRAC_W   = 8;
    localparam int PRF_SHIFT    = 16;
    localparam int PRF_SUM_W    = PRF_PROD_W + PRF_FRAC_W + 1;

    // filter coefficient 6/11 and its complement, q16
    localparam logic [PRF_COEF_W-1:0] PRF_COEF_Q16      = 16'd35747;
    localparam logic [PRF_COEF_W-1:0] PRF_COEF_REST_Q16 = 16'd29789;
    localparam logic [PRF_SUM_W-1:0]  PRF_ROUND         = PRF_SUM_W'(32768);

    localparam logic [PRF_DIST_W-1:0] PRF_DIST_MAX   = 17'd131071;
    localparam logic [PRF_DIST_W-1:0] PRF_RESET_DIST = 17'd1500;
    localparam logic [PRF_FILT_W-1:0] PRF_RESET_FILT = 25'd384000;
    localparam logic [PRF_THR_W-1:0]  PRF_RESET_THR  = 16'd1000;
    localparam logic [PRF_PROD_W-1:0] PRF_RESET_PROD = PRF_PROD_W'(35747 * 1500);

    localparam int PRF_OUT_DEPTH = 4;

    // apb register map
    localparam int PRF_APB_ADDR_W = 3;
    localparam int PRF_APB_DATA_W = 32;
    localparam logic REG_THRESHOLD = 1'b0;   // word index in paddr[2]

    // command and event codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [1:0] LVL_FALL    = 2'd0;
    localparam logic [1:0] LVL_RISE    = 2'd1;
    localparam logic [1:0] LVL_TIMEOUT = 2'd2;

    typedef struct packed {
        logic                  cmd;
        logic [1:0]            level;
        logic [PRF_TICK_W-1:0] tick;
    } t_in_item;

    typedef struct packed {
        logic [PRF_FILT_W-1:0] distance_q8;
        logic                  is_safe;
        logic                  busy_res;
    } t_out_item;

endpackage

// ----- sv/pulse_range_filter_threshold_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_range_filter_threshold_core
// Range sensor pulse timing with a first-order low-pass distance filter.
// ----------------------------------------------------------------------------
// Takes one item per clock when not stalled. An event item (edge or watchdog
// timeout) updates the pulse timing state and yields no result; a read item
// yields exactly one result, written into the result queue from the input
// register. Every item passes through one input register and combinational
// logic: a 32-bit tick subtract with saturation for falling edges, and one
// 15x25 multiply plus add for the filter update. The measurement half of the
// filter (35747 * distance) is formed when the distance changes, so a
// read does one multiply and add. Results go into a four-entry queue; the
// input stall is computed from registers only (queued results plus a read in
// the input register), which lets the block run at one item per cycle while
// the output takes one per cycle, and stalls the input only once the queue is
// genuinely backing up. The threshold register sits at byte address 0 of the
// APB port and should be written while the block is idle.
// ----------------------------------------------------------------------------
module pulse_range_filter_threshold_core #(
    parameter int OUT_DEPTH = prf_pkg::PRF_OUT_DEPTH   // at least 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item input
    input  logic                                 i_in_valid,
    input  prf_pkg::t_in_item                    i_in_data,
    output logic                                 o_in_stall,
    // result output
    output logic                                 o_out_valid,
    output prf_pkg::t_out_item                   o_out_data,
    input  logic                                 i_out_stall,
    // apb configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prf_pkg::PRF_APB_ADDR_W-1:0]   paddr,
    input  logic [prf_pkg::PRF_APB_DATA_W-1:0]   pwdata,
    output logic [prf_pkg::PRF_APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);
    import prf_pkg::*;

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [PRF_THR_W-1:0] w_threshold;
    logic                 w_accept;
    logic                 w_push;
    t_out_item            w_push_data;
    logic                 w_read_pending;
    logic [CNT_W-1:0]     w_count;
    logic [CNT_W:0]       w_committed;

    // register slave
    prf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (w_threshold)
    );

    // results already queued plus a read about to be pushed; all from
    // registers, so the output stall never reaches the input stall directly
    assign w_committed = (CNT_W + 1)'(w_count) + (CNT_W + 1)'(w_read_pending);
    assign o_in_stall  = (w_committed >= (CNT_W + 1)'(OUT_DEPTH));
    assign w_accept    = i_in_valid && !o_in_stall;

    // timing state and filter
    prf_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_in_data      (i_in_data),
        .i_threshold    (w_threshold),
        .o_push         (w_push),
        .o_push_data    (w_push_data),
        .o_read_pending (w_read_pending)
    );

    // result queue
    prf_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_count     (w_count)
    );

endmodule

// ----- sv/prf_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_cfg
// APB register slave holding the safety threshold.
// ----------------------------------------------------------------------------
module prf_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prf_pkg::PRF_APB_ADDR_W-1:0]   paddr,
    input  logic [prf_pkg::PRF_APB_DATA_W-1:0]   pwdata,
    output logic [prf_pkg::PRF_APB_DATA_W-1:0]   prdata,
    output logic                                 pready,
    output logic [prf_pkg::PRF_THR_W-1:0]        o_threshold
);
    import prf_pkg::*;

    logic [PRF_THR_W-1:0] r_threshold;
    logic                 w_sel_thr;

    assign w_sel_thr = (paddr[2] == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= PRF_RESET_THR;
        end else if (psel && penable && pwrite && w_sel_thr) begin
            r_threshold <= pwdata[PRF_THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_thr) begin
            prdata = PRF_APB_DATA_W'(r_threshold);
        end
    end

    assign pready      = 1'b1;
    assign o_threshold = r_threshold;

endmodule

// ----- sv/prf_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_core
// Input register, pulse timing state and low-pass filter update.
// ----------------------------------------------------------------------------
module prf_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  prf_pkg::t_in_item             i_in_data,
    input  logic [prf_pkg::PRF_THR_W-1:0] i_threshold,
    output logic                          o_push,
    output prf_pkg::t_out_item            o_push_data,
    output logic                          o_read_pending
);
    import prf_pkg::*;

    logic                  r_in_valid;
    t_in_item              r_in;
    logic [PRF_TICK_W-1:0] r_start,   n_start;
    logic                  r_in_pulse, n_in_pulse;
    logic [PRF_DIST_W-1:0] r_last,    n_last;
    logic [PRF_PROD_W-1:0] r_prod,    n_prod;
    logic [PRF_FILT_W-1:0] r_filt,    n_filt;

    logic [PRF_TICK_W-1:0] w_diff;
    logic [PRF_SUM_W-1:0]  w_sum;
    logic                  w_event;
    logic                  w_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_start    <= '0;
            r_in_pulse <= 1'b0;
            r_last     <= PRF_RESET_DIST;
            r_prod     <= PRF_RESET_PROD;
            r_filt     <= PRF_RESET_FILT;
        end else begin
            r_in_valid <= i_accept;
            r_start    <= n_start;
            r_in_pulse <= n_in_pulse;
            r_last     <= n_last;
            r_prod     <= n_prod;
            r_filt     <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_in_data;
        end
    end

    assign w_event = r_in_valid && (r_in.cmd == CMD_EVENT);
    assign w_read  = r_in_valid && (r_in.cmd == CMD_READ);
    assign w_diff  = r_in.tick - r_start;

    // edge and timeout events
    always_comb begin
        n_start    = r_start;
        n_in_pulse = r_in_pulse;
        n_last     = r_last;
        if (w_event) begin
            case (r_in.level)
                LVL_RISE: begin
                    n_start    = r_in.tick;
                    n_in_pulse = 1'b1;
                end
                LVL_FALL: begin
                    n_start    = w_diff;
                    n_in_pulse = 1'b0;
                    if (w_diff != '0) begin
                        if (w_diff > PRF_TICK_W'(PRF_DIST_MAX)) begin
                            n_last = PRF_DIST_MAX;
                        end else begin
                            n_last = w_diff[PRF_DIST_W-1:0];
                        end
                    end
                end
                default: begin
                    // timeout, and the spare code too
                    n_in_pulse = 1'b0;
                    n_last     = PRF_DIST_W'(i_threshold)
                               + PRF_DIST_W'(i_threshold >> 1);
                end
            endcase
        end
    end

    // measurement term of the filter, kept ready for the next read
    assign n_prod = PRF_PROD_W'(PRF_PROD_W'(PRF_COEF_Q16) * PRF_PROD_W'(n_last));

    assign w_sum = PRF_SUM_W'({r_prod, {PRF_FRAC_W{1'b0}}})
                 + PRF_SUM_W'(PRF_SUM_W'(PRF_COEF_REST_Q16) * PRF_SUM_W'(r_filt))
                 + PRF_ROUND;

    always_comb begin
        n_filt = r_filt;
        if (w_read && !r_in_pulse) begin
            n_filt = w_sum[PRF_SHIFT +: PRF_FILT_W];
        end
    end

    assign o_push                  = w_read;
    assign o_push_data.distance_q8 = n_filt;
    assign o_push_data.is_safe     = (n_filt > PRF_FILT_W'({i_threshold, {PRF_FRAC_W{1'b0}}}));
    assign o_push_data.busy_res    = r_in_pulse;
    assign o_read_pending          = w_read;

endmodule

// ----- sv/prf_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_outq
// Small result queue between the filter and the output channel.
// ----------------------------------------------------------------------------
module prf_outq #(
    parameter int DEPTH = prf_pkg::PRF_OUT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  prf_pkg::t_out_item            i_push_data,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output prf_pkg::t_out_item            o_out_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import prf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_out_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_pop;

    assign w_pop = (r_cnt != '0) && !i_out_stall;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_mem[r_rp];
    assign o_count     = r_cnt;

endmodule

// ----- sv/prf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_checker
// Port-level checks for the pulse range filter block, bound to the top.
// ----------------------------------------------------------------------------
module prf_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_in_stall,
    input  logic                                 o_out_valid,
    input  prf_pkg::t_out_item                   o_out_data,
    input  logic                                 i_out_stall,
    input  logic                                 pready
);
    import prf_pkg::*;

    // distance of the last result taken
    logic [PRF_FILT_W-1:0] r_last_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dist <= PRF_RESET_FILT;
        end else if (o_out_valid && !i_out_stall) begin
            r_last_dist <= o_out_data.distance_q8;
        end
    end

    // a busy read leaves the filter alone
    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.busy_res |-> o_out_data.distance_q8 == r_last_dist)
        else $error("busy result changed the filtered distance");

    // nothing pending straight out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind pulse_range_filter_threshold_core prf_checker u_prf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall),
    .pready      (pready)
);

// ----- dv/prf_range_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_range_checker
// Watches the item, result and register channels of the pulse range filter,
// predicts every read result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module prf_range_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  prf_pkg::t_in_item                    i_in_data,
    input  logic                                 i_in_stall,
    input  logic                                 i_out_valid,
    input  prf_pkg::t_out_item                   i_out_data,
    input  logic                                 i_out_stall,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [prf_pkg::PRF_APB_ADDR_W-1:0]   paddr,
    input  logic [prf_pkg::PRF_APB_DATA_W-1:0]   pwdata,
    input  logic                                 pready,
    output int                                   o_mismatches,
    output int                                   o_outstanding,
    output int                                   o_checked,
    output int                                   o_busy_seen
);
    import prf_pkg::*;

    localparam logic [63:0] FILT_GAIN_Q16 = 64'd35747;          // 6/11 in q16
    localparam logic [63:0] FILT_KEEP_Q16 = 64'd65536 - 64'd35747;
    localparam logic [63:0] FILT_ROUND    = 64'd32768;
    localparam logic [16:0] DIST_CEIL     = 17'h1FFFF;

    logic [15:0] thr_mm;
    logic [31:0] pulse_start;
    logic        pulse_active;
    logic [16:0] raw_dist_mm;
    logic [24:0] filt_q8;
    t_out_item   expected_readings[$];

    function automatic void predict_range_reading(input t_in_item it);
        logic [31:0] width;
        logic [63:0] acc;
        t_out_item   reading;
        if (it.cmd == CMD_READ) begin
            // a read during a pulse leaves the filter alone
            if (!pulse_active) begin
                acc = FILT_GAIN_Q16 * 64'({raw_dist_mm, 8'd0})
                    + FILT_KEEP_Q16 * 64'(filt_q8) + FILT_ROUND;
                filt_q8 = acc[40:16];
            end
            reading.distance_q8 = filt_q8;
            reading.is_safe     = (filt_q8 > {1'b0, thr_mm, 8'd0});
            reading.busy_res    = pulse_active;
            expected_readings.push_back(reading);
        end else begin
            case (it.level)
                LVL_RISE: begin
                    pulse_start  = it.tick;
                    pulse_active = 1'b1;
                end
                LVL_FALL: begin
                    width       = it.tick - pulse_start;
                    pulse_start = width;
                    if (width != '0)
                        raw_dist_mm = (width > 32'(DIST_CEIL)) ? DIST_CEIL : width[16:0];
                    pulse_active = 1'b0;
                end
                default: begin
                    // timeout and the spare level code: 1.5 x threshold
                    raw_dist_mm  = {1'b0, thr_mm} + {2'b00, thr_mm[15:1]};
                    pulse_active = 1'b0;
                end
            endcase
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            thr_mm        = PRF_RESET_THR;
            pulse_start   = '0;
            pulse_active  = 1'b0;
            raw_dist_mm   = PRF_RESET_DIST;
            filt_q8       = PRF_RESET_FILT;
            expected_readings.delete();
            o_mismatches  = 0;
            o_checked     = 0;
            o_busy_seen   = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD)
                thr_mm = pwdata[15:0];
            if (i_in_valid && !i_in_stall)
                predict_range_reading(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("unexpected result: dist=%0d safe=%0d busy=%0d",
                                 i_out_data.distance_q8, i_out_data.is_safe,
                                 i_out_data.busy_res);
                    o_mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    o_checked++;
                    if (i_out_data.busy_res)
                        o_busy_seen++;
                    if (i_out_data.distance_q8 !== want.distance_q8 ||
                        i_out_data.is_safe !== want.is_safe ||
                        i_out_data.busy_res !== want.busy_res) begin
                        if (o_mismatches < 10) begin
                            $display("mismatch: want dist=%0d safe=%0d busy=%0d",
                                     want.distance_q8, want.is_safe, want.busy_res);
                            $display("          got  dist=%0d safe=%0d busy=%0d",
                                     i_out_data.distance_q8, i_out_data.is_safe,
                                     i_out_data.busy_res);
                        end
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_readings.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the pulse range filter threshold core.
// ----------------------------------------------------------------------------
// A directed opening covers reset values, tick wrap, falling edges with a zero
// or missing rising edge, distance saturation, timeouts, the spare level code,
// busy reads and threshold extremes. Random phases then send mostly complete
// pulses (rise, busy reads, fall, reads) with noise items mixed in, each phase
// under its own threshold and one of four idling mixes. A separate checker
// predicts and compares the results; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb_top;

    import prf_pkg::*;

    localparam int          LIMIT_CYCLES   = 400000;
    localparam int          SETTLE_CYCLES  = 6;     // input register plus pipe
    localparam int          PHASES         = 6;
    localparam int          PHASE_ITEMS    = 270;
    localparam logic        REG_UNUSED     = 1'b1;  // word index 1, no register
    localparam logic [1:0]  LVL_SPARE      = 2'd3;  // unused code, acts as timeout

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_data;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    logic       i_out_stall = 1'b0;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [PRF_APB_ADDR_W-1:0] paddr;
    logic [PRF_APB_DATA_W-1:0] pwdata;
    logic [PRF_APB_DATA_W-1:0] prdata;
    logic       pready;

    int mismatches;
    int outstanding;
    int checked;
    int busy_seen;

    int send_idle_pct = 0;      // chance in a hundred of an idle sender cycle
    int stall_pct     = 0;      // chance in a hundred of a receiver stall
    int items_sent    = 0;
    int thr_writes    = 0;
    int cycle_count   = 0;

    always #5 i_clk = ~i_clk;

    pulse_range_filter_threshold_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    prf_range_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_out_data    (o_out_data),
        .i_out_stall   (i_out_stall),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_busy_seen   (busy_seen)
    );

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // one item onto the input channel; starts and ends at a falling edge
    task automatic send_sensor_item(input logic cmd, input logic [1:0] lvl,
                                    input logic [31:0] tick);
        t_in_item it;
        it.cmd   = cmd;
        it.level = lvl;
        it.tick  = tick;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    // level and tick are don't-care on a read, so they get random values
    task automatic send_read();
        send_sensor_item(CMD_READ, 2'($urandom_range(3)), $urandom());
    endtask

    // drop valid, wait for every result, then let the pipe empty
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup cycle then access cycle; only called while the block is idle
    task automatic apb_write(input logic word, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {word, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (word == REG_THRESHOLD)
            thr_writes++;
    endtask

    // a complete pulse: rise, reads while busy, fall, then reads
    task automatic pulse_burst();
        logic [31:0] t0;
        logic [31:0] width;
        int          sel;
        t0  = $urandom();
        sel = $urandom_range(99);
        if (sel < 50)
            width = $urandom_range(4000);
        else if (sel < 75)
            width = $urandom_range(140000, 4000);   // straddles saturation
        else if (sel < 85)
            width = '0;
        else
            width = $urandom();
        send_sensor_item(CMD_EVENT, LVL_RISE, t0);
        repeat ($urandom_range(2)) send_read();
        send_sensor_item(CMD_EVENT, LVL_FALL, t0 + width);
        repeat ($urandom_range(3, 1)) send_read();
    endtask

    initial begin
        logic [15:0] phase_thr [PHASES];
        int          sel;
        int          phase_start;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        phase_thr  = '{16'd0, 16'hFFFF, 16'd1000, 16'($urandom()), 16'($urandom()), 16'd1};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed opening, no idling ----
        // reset state read back, with every ignored bit set
        send_sensor_item(CMD_READ, LVL_SPARE, 32'hFFFF_FFFF);
        // pulse across the tick wrap, with a busy read inside
        send_sensor_item(CMD_EVENT, LVL_RISE, 32'hFFFF_FFF0);
        send_sensor_item(CMD_READ, LVL_FALL, 32'h0);
        send_sensor_item(CMD_EVENT, LVL_FALL, 32'h0000_0010);
        send_read();
        // fall with no rise: difference against the stored width is zero
        send_sensor_item(CMD_EVENT, LVL_FALL, 32'h0000_0020);
        send_read();
        // longest possible pulse saturates the distance
        send_sensor_item(CMD_EVENT, LVL_RISE, 32'h0);
        send_sensor_item(CMD_EVENT, LVL_FALL, 32'hFFFF_FFFF);
        send_read();
        // pulse exactly at the distance ceiling
        send_sensor_item(CMD_EVENT, LVL_RISE, 32'd100);
        send_sensor_item(CMD_EVENT, LVL_FALL, 32'd100 + 32'd131071);
        send_read();
        // watchdog timeout and the spare level code
        send_sensor_item(CMD_EVENT, LVL_TIMEOUT, $urandom());
        send_read();
        send_sensor_item(CMD_EVENT, LVL_SPARE, $urandom());
        send_read();
        // timeout ends a pulse in progress
        send_sensor_item(CMD_EVENT, LVL_RISE, 32'd7);
        send_sensor_item(CMD_EVENT, LVL_TIMEOUT, 32'd0);
        send_read();

        // threshold at zero, upper data bits set and ignored
        settle_block();
        apb_write(REG_THRESHOLD, 32'hABCD_0000);
        send_sensor_item(CMD_EVENT, LVL_TIMEOUT, $urandom());
        send_read();
        // a write to the empty word must not touch the threshold
        settle_block();
        apb_write(REG_UNUSED, 32'h0000_0005);
        // the bus goes idle between the two transfers
        @(negedge i_clk);
        apb_write(REG_THRESHOLD, 32'hFFFF_FFFF);
        send_sensor_item(CMD_EVENT, LVL_SPARE, $urandom());
        send_read();
        send_read();

        // ---- random phases, each with its own threshold and one of four idling mixes ----
        for (int phase = 0; phase < PHASES; phase++) begin
            settle_block();
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            apb_write(REG_THRESHOLD, {16'($urandom()), phase_thr[phase]});
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                if (sel < 65) begin
                    pulse_burst();
                end else if (sel < 78) begin
                    send_sensor_item(CMD_EVENT, $urandom_range(1) ? LVL_TIMEOUT : LVL_SPARE,
                                     $urandom());
                    repeat ($urandom_range(2, 1)) send_read();
                end else begin
                    // noise: anything the fields allow, including stray falls
                    repeat ($urandom_range(3, 1))
                        send_sensor_item(1'($urandom_range(1)), 2'($urandom_range(3)),
                                         $urandom());
                end
            end
        end

        settle_block();
        repeat (10) @(negedge i_clk);

        $display("run covered %0d items and %0d checked results (%0d busy reads)",
                 items_sent, checked, busy_seen);
        $display("over %0d threshold writes and %0d idling mixes", thr_writes, 4);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/prf_pkg.sv
sv/prf_cfg.sv
sv/prf_core.sv
sv/prf_outq.sv
sv/pulse_range_filter_threshold_core.sv
sv/prf_checker.sv
dv/prf_range_checker.sv
dv/tb_top.sv
